// ----- rtl/sbbs_pkg.sv -----
// shared types, constants and codes of the size bucketed budget selector
// no dependencies; imported by every module of the block
package sbbs_pkg;

   localparam int NUM_CLASSES = 50;
   localparam int POOL_DEPTH  = 64;

   localparam int POOL_W  = $clog2(POOL_DEPTH);
   localparam int SCAN_W  = POOL_W + 1;
   localparam int CLS_W   = 6;
   localparam int CNT_W   = 7;
   localparam int CIDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_W     = $clog2(CMDQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_W     = $clog2(RSPQ_DEPTH);

   localparam logic [5:0]  MAX_SIZE_RST   = 6'd50;
   localparam logic [15:0] COST_LIMIT_RST = 16'd10000;

   localparam logic REG_MAX_SIZE   = 1'b0;
   localparam logic REG_COST_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SELECT = 3'd1,
      OP_TAKE   = 3'd2,
      OP_DRAIN  = 3'd3,
      OP_CNTALL = 3'd4,
      OP_CNTCLS = 3'd5,
      OP_CLEAR  = 3'd6,
      OP_NOP    = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [5:0]  item_size;
      logic [31:0] handle;
      logic [15:0] budget;
   } req_type;

   typedef struct packed {
      logic [31:0] out_handle;
      logic        handle_valid;
      logic        accepted;
      logic [15:0] used;
      logic [6:0]  count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [5:0]       item_size;
      logic [CLS_W-1:0] cls;
      logic             size_nz;
      logic             size_in_range;
      logic [31:0]      handle;
      logic [15:0]      budget;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  max_size;
      logic [15:0] cost_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0]      handle;
      logic [CLS_W-1:0] cls;
      logic [15:0]      stamp;
   } entry_type;

endpackage

// ----- rtl/sbbs_front.sv -----
// front end: accepts requests, classifies them and queues them for the engine
// depends on sbbs_pkg
module sbbs_front
   import sbbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req,
   output logic    empty,
   input  logic    pop,
   output cmd_type cmd
);

   cmd_type             q_ff [CMDQ_DEPTH];
   logic [CMDQ_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CMDQ_W:0]     num_ff, num_in;
   cmd_type             cls_cmd;
   logic                do_push, do_pop;

   always_comb begin
      cls_cmd.op            = op_type'(req.opcode);
      cls_cmd.item_size     = req.item_size;
      cls_cmd.cls           = req.item_size - 6'd1;
      cls_cmd.size_nz       = |req.item_size;
      cls_cmd.size_in_range = {1'b0, req.item_size} <= 7'(NUM_CLASSES);
      cls_cmd.handle        = req.handle;
      cls_cmd.budget        = req.budget;
   end

   assign full    = num_ff == (CMDQ_W+1)'(CMDQ_DEPTH);
   assign empty   = num_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign cmd     = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      num_in = num_ff;
      if (do_push) begin
         wr_in = (wr_ff == CMDQ_W'(CMDQ_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == CMDQ_W'(CMDQ_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         num_in = num_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         num_in = num_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         num_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= cls_cmd;
      end
   end

endmodule

// ----- rtl/sbbs_rsp_fifo.sv -----
// result queue between the engine and the result ports
// depends on sbbs_pkg
module sbbs_rsp_fifo
   import sbbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  rsp_type din,
   output logic    empty,
   input  logic    pop,
   output rsp_type dout
);

   rsp_type           q_ff [RSPQ_DEPTH];
   logic [RSPQ_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [RSPQ_W:0]   num_ff, num_in;
   logic              do_push, do_pop;

   assign full    = num_ff == (RSPQ_W+1)'(RSPQ_DEPTH);
   assign empty   = num_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      num_in = num_ff;
      if (do_push) begin
         wr_in = (wr_ff == RSPQ_W'(RSPQ_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == RSPQ_W'(RSPQ_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         num_in = num_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         num_in = num_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         num_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= din;
      end
   end

endmodule

// ----- rtl/sbbs_engine.sv -----
// back end: pool memory, class counts and the sequencer that carries out requests
// depends on sbbs_pkg
module sbbs_engine
   import sbbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    res_full,
   output logic    res_push,
   output rsp_type res
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_CRD   = 11'b00000000010,
      ST_CCHK  = 11'b00000000100,
      ST_FREE  = 11'b00000001000,
      ST_SNEXT = 11'b00000010000,
      ST_DNEXT = 11'b00000100000,
      ST_SCAN  = 11'b00001000000,
      ST_PDONE = 11'b00010000000,
      ST_END   = 11'b00100000000,
      ST_TNEXT = 11'b01000000000,
      ST_WAIT  = 11'b10000000000
   } state_type;

   entry_type             ent_mem [POOL_DEPTH];
   entry_type             ent_q;
   logic                  ent_we, ent_re;
   logic [POOL_W-1:0]     ent_waddr, ent_raddr;
   entry_type             ent_wdata;

   logic [CNT_W-1:0]      cnt_mem [NUM_CLASSES];
   logic [CNT_W-1:0]      cnt_q, cnt_rd, cnt_wdata;
   logic                  cnt_we, cnt_re, cnt_vq_ff;
   logic [CIDX_W-1:0]     c_idx;

   state_type             st_ff, st_in;
   cmd_type               cmd_ff, cmd_in;
   logic [CLS_W:0]        c_ff, c_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic                  partial_ff, partial_in;
   logic [15:0]           used_ff, used_in, left_ff, left_in;
   logic [SCAN_W-1:0]     sc_ff, sc_in;
   logic                  rvld_ff, rvld_in;
   logic [POOL_W-1:0]     ridx_ff, ridx_in;
   logic                  clr_ff, clr_in;
   logic                  found_ff, found_in;
   logic [POOL_W-1:0]     best_ff, best_in;
   logic [15:0]           bage_ff, bage_in;
   logic [31:0]           bhnd_ff, bhnd_in;
   rsp_type               hold_ff, hold_in, res_ff, res_in;
   logic                  hold_vld_ff, hold_vld_in;
   logic [POOL_DEPTH-1:0] valid_ff, valid_in;
   logic [NUM_CLASSES-1:0] cvld_ff, cvld_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [15:0]           arr_ff, arr_in;

   logic [CLS_W:0]        lim, s_cur;
   logic [13:0]           add_prod, sel_prod;
   logic                  add_ok;
   logic [15:0]           age;
   logic                  issue;

   assign c_idx  = c_ff[CIDX_W-1:0];
   assign cnt_rd = cnt_vq_ff ? cnt_q : '0;
   assign lim    = ({1'b0, cfg.max_size} < (CLS_W+1)'(NUM_CLASSES)) ?
                   {1'b0, cfg.max_size} : (CLS_W+1)'(NUM_CLASSES);
   assign s_cur  = c_ff + 1'b1;
   assign add_prod = (14'(cnt_rd) + 14'd1) * 14'(cmd_ff.item_size);
   assign sel_prod = 14'(s_cur) * 14'(cnt_rd);
   assign add_ok = cmd_ff.size_nz && ({1'b0, cmd_ff.item_size} <= lim) &&
                   (total_ff < CNT_W'(POOL_DEPTH)) && ({2'b0, add_prod} < cfg.cost_limit);
   assign age    = arr_ff - ent_q.stamp;
   assign issue  = sc_ff < SCAN_W'(POOL_DEPTH);

   always_comb begin
      st_in       = st_ff;
      cmd_in      = cmd_ff;
      c_in        = c_ff;
      rem_in      = rem_ff;
      partial_in  = partial_ff;
      used_in     = used_ff;
      left_in     = left_ff;
      sc_in       = sc_ff;
      rvld_in     = 1'b0;
      ridx_in     = ridx_ff;
      clr_in      = clr_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      bage_in     = bage_ff;
      bhnd_in     = bhnd_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      res_in      = res_ff;
      valid_in    = valid_ff;
      cvld_in     = cvld_ff;
      total_in    = total_ff;
      arr_in      = arr_ff;
      cmd_pop     = 1'b0;
      res_push    = 1'b0;
      res         = res_ff;
      ent_we      = 1'b0;
      ent_re      = 1'b0;
      ent_waddr   = sc_ff[POOL_W-1:0];
      ent_raddr   = sc_ff[POOL_W-1:0];
      ent_wdata   = '{handle: cmd_ff.handle, cls: cmd_ff.cls, stamp: arr_ff};
      cnt_we      = 1'b0;
      cnt_re      = 1'b0;
      cnt_wdata   = rem_ff + 1'b1;

      unique case (st_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               res_in  = '0;
               used_in = '0;
               left_in = cmd.budget;
               c_in    = '0;
               case (cmd.op)
                  OP_ADD: begin
                     c_in  = {1'b0, cmd.cls};
                     st_in = ST_CRD;
                  end
                  OP_SELECT: begin
                     st_in = (lim == '0) ? ST_END : ST_CRD;
                  end
                  OP_TAKE, OP_DRAIN: begin
                     st_in = ST_CRD;
                  end
                  OP_CNTALL: begin
                     res_in.count = total_ff;
                     st_in        = ST_END;
                  end
                  OP_CNTCLS: begin
                     c_in  = {1'b0, cmd.cls};
                     st_in = (cmd.size_nz && cmd.size_in_range) ? ST_CRD : ST_END;
                  end
                  OP_CLEAR: begin
                     if (cmd.size_nz) begin
                        for (int i = 0; i < NUM_CLASSES; i++) begin
                           if ((CLS_W+1)'(i) >= {1'b0, cmd.cls}) begin
                              cvld_in[i] = 1'b0;
                           end
                        end
                        res_in.accepted = 1'b1;
                        clr_in          = 1'b1;
                        sc_in           = '0;
                        st_in           = ST_SCAN;
                     end else begin
                        st_in = ST_END;
                     end
                  end
                  default: begin
                     st_in = ST_END;
                  end
               endcase
            end
         end

         ST_CRD: begin
            cnt_re = 1'b1;
            st_in  = ST_CCHK;
         end

         ST_CCHK: begin
            rem_in = cnt_rd;
            case (cmd_ff.op)
               OP_ADD: begin
                  sc_in = '0;
                  st_in = add_ok ? ST_FREE : ST_END;
               end
               OP_SELECT: begin
                  partial_in = left_ff < {2'b0, sel_prod};
                  st_in      = (left_ff < 16'(s_cur)) ? ST_END : ST_SNEXT;
               end
               OP_TAKE: begin
                  st_in = ST_TNEXT;
               end
               OP_DRAIN: begin
                  st_in = ST_DNEXT;
               end
               default: begin
                  res_in.count = cnt_rd;
                  st_in        = ST_END;
               end
            endcase
         end

         ST_FREE: begin
            if (!valid_ff[sc_ff[POOL_W-1:0]]) begin
               ent_we          = 1'b1;
               cnt_we          = 1'b1;
               valid_in[sc_ff[POOL_W-1:0]] = 1'b1;
               cvld_in[c_idx]  = 1'b1;
               arr_in          = arr_ff + 16'd1;
               total_in        = total_ff + 1'b1;
               res_in.accepted = 1'b1;
               st_in           = ST_END;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end

         ST_SNEXT: begin
            if (rem_ff != '0 && left_ff >= 16'(s_cur)) begin
               clr_in   = 1'b0;
               found_in = 1'b0;
               sc_in    = '0;
               st_in    = ST_SCAN;
            end else if (partial_ff || s_cur >= lim) begin
               st_in = ST_END;
            end else begin
               c_in  = s_cur;
               st_in = ST_CRD;
            end
         end

         ST_TNEXT: begin
            if (rem_ff != '0) begin
               clr_in   = 1'b0;
               found_in = 1'b0;
               sc_in    = '0;
               st_in    = ST_SCAN;
            end else if (s_cur >= (CLS_W+1)'(NUM_CLASSES)) begin
               st_in = ST_END;
            end else begin
               c_in  = s_cur;
               st_in = ST_CRD;
            end
         end

         ST_DNEXT: begin
            if (rem_ff != '0) begin
               clr_in   = 1'b0;
               found_in = 1'b0;
               sc_in    = '0;
               st_in    = ST_SCAN;
            end else if (s_cur >= (CLS_W+1)'(NUM_CLASSES)) begin
               st_in = ST_END;
            end else begin
               c_in  = s_cur;
               st_in = ST_CRD;
            end
         end

         ST_SCAN: begin
            // read one entry a cycle, judge it the cycle after
            if (issue) begin
               ent_re  = 1'b1;
               sc_in   = sc_ff + 1'b1;
               rvld_in = 1'b1;
               ridx_in = sc_ff[POOL_W-1:0];
            end
            if (rvld_ff && valid_ff[ridx_ff]) begin
               if (clr_ff) begin
                  if (ent_q.cls >= cmd_ff.cls) begin
                     valid_in[ridx_ff] = 1'b0;
                     total_in          = total_in - 1'b1;
                  end
               end else if (ent_q.cls == c_ff[CLS_W-1:0] &&
                            (!found_ff || age > bage_ff)) begin
                  found_in = 1'b1;
                  best_in  = ridx_ff;
                  bage_in  = age;
                  bhnd_in  = ent_q.handle;
               end
            end
            if (!issue && !rvld_ff) begin
               st_in = clr_ff ? ST_END : ST_PDONE;
            end
         end

         ST_PDONE: begin
            if (!(hold_vld_ff && res_full)) begin
               if (hold_vld_ff) begin
                  res      = hold_ff;
                  res_push = 1'b1;
               end
               if (found_ff) begin
                  valid_in[best_ff] = 1'b0;
                  total_in          = total_ff - 1'b1;
               end
               cnt_we      = 1'b1;
               cnt_wdata   = rem_ff - 1'b1;
               rem_in      = rem_ff - 1'b1;
               hold_in     = '0;
               hold_in.out_handle   = bhnd_ff;
               hold_in.handle_valid = 1'b1;
               hold_vld_in = 1'b1;
               case (cmd_ff.op)
                  OP_SELECT: begin
                     used_in      = used_ff + 16'(s_cur);
                     left_in      = left_ff - 16'(s_cur);
                     hold_in.used = used_ff + 16'(s_cur);
                     st_in        = ST_SNEXT;
                  end
                  OP_DRAIN: begin
                     st_in = ST_DNEXT;
                  end
                  default: begin
                     st_in = ST_END;
                  end
               endcase
            end
         end

         ST_END: begin
            if (!res_full) begin
               res         = hold_vld_ff ? hold_ff : res_in;
               res.last    = 1'b1;
               res_push    = 1'b1;
               hold_vld_in = 1'b0;
               st_in       = ST_WAIT;
            end
         end

         ST_WAIT: begin
            st_in = ST_IDLE;
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_q <= ent_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[c_idx] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_q     <= cnt_mem[c_idx];
         cnt_vq_ff <= cvld_ff[c_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         hold_vld_ff <= 1'b0;
         rvld_ff     <= 1'b0;
         valid_ff    <= '0;
         cvld_ff     <= '0;
         total_ff    <= '0;
         arr_ff      <= '0;
      end else begin
         st_ff       <= st_in;
         hold_vld_ff <= hold_vld_in;
         rvld_ff     <= rvld_in;
         valid_ff    <= valid_in;
         cvld_ff     <= cvld_in;
         total_ff    <= total_in;
         arr_ff      <= arr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      c_ff       <= c_in;
      rem_ff     <= rem_in;
      partial_ff <= partial_in;
      used_ff    <= used_in;
      left_ff    <= left_in;
      sc_ff      <= sc_in;
      ridx_ff    <= ridx_in;
      clr_ff     <= clr_in;
      found_ff   <= found_in;
      best_ff    <= best_in;
      bage_ff    <= bage_in;
      bhnd_ff    <= bhnd_in;
      hold_ff    <= hold_in;
      res_ff     <= res_in;
   end

endmodule

// ----- rtl/size_bucketed_budget_selector.sv -----
// top level of the size bucketed budget selector: register port and the
// front queue, engine and result queue; depends on sbbs_pkg and the sbbs_ modules
//
// Holds up to 64 handles in one pool, filed in first-in first-out classes
// by size. Requests go in through a queue-style push/full port and results
// come out through an empty/pop port; a two-deep request queue and a
// four-deep result queue let both sides stall on their own. Requests are
// carried out one at a time. Every removal of a handle scans the whole pool
// through the single entry memory read port, one entry a cycle; an add
// steps through the pool entries looking for a free one, and a clear scans
// the whole pool. A select visits the size classes in turn up to the size
// limit, and a drain visits every size class, through the class count
// memory, plus one pool scan per handle it removes. No clearing pass is
// needed after reset.
module size_bucketed_budget_selector
   import sbbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   // result side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;
   logic    cmd_empty, cmd_pop;
   cmd_type cmd;
   logic    res_full, res_push;
   rsp_type res;

   // register file: max_size at 0, cost_limit at 4
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MAX_SIZE:   cfg_in.max_size   = csr_pwdata[5:0];
            REG_COST_LIMIT: cfg_in.cost_limit = csr_pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // low address bits only select a byte lane, so reads decode bit 2 alone
   assign csr_prdata = (csr_paddr[2] == REG_COST_LIMIT) ? {16'b0, cfg_ff.cost_limit} :
                       {26'b0, cfg_ff.max_size} | {29'b0, csr_paddr[1:0] & 2'b00, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_size   <= MAX_SIZE_RST;
         cfg_ff.cost_limit <= COST_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: request queue with size classification
   sbbs_front u_front (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .req   (req_data),
      .empty (cmd_empty),
      .pop   (cmd_pop),
      .cmd   (cmd)
   );

   // back: pool, class counts and sequencer
   sbbs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res)
   );

   // results wait here until taken
   sbbs_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .din   (res),
      .empty (rsp_empty),
      .pop   (rsp_pop),
      .dout  (rsp_data)
   );

endmodule

// ----- rtl/sbbs_checker.sv -----
// port level checks of the size bucketed budget selector and their bind
// depends on sbbs_pkg and the top level
module sbbs_checker
   import sbbs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data,
   input logic    csr_pready
);

   // result queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // a removed handle carries no add, count or clear answer
   a_handle_only: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.handle_valid) |->
      (!rsp_data.accepted && rsp_data.count == '0))
      else $error("handle result mixes fields");

   // without a handle the handle field is zero, nothing was spent and the result is the last
   a_no_handle: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.handle_valid) |->
      (rsp_data.out_handle == '0 && rsp_data.used == '0 && rsp_data.last))
      else $error("empty result carries data");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind size_bucketed_budget_selector sbbs_checker u_sbbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
